/* sv/pte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types and register codes for the polyline tangent estimator.
// ----------------------------------------------------------------------------
package pte_pkg;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_stat;

    localparam logic REG_LAST_LEN = 1'b0;
    localparam logic REG_ZERO_TOL = 1'b1;

    localparam int UNIT_SHIFT = 30;

endpackage

/* sv/pte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_if
// Point and tangent stream channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pte_pt_if #(parameter int CW = 32);
    logic          valid;
    logic          ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic          final_point;

    modport source (output valid, point_x, point_y, point_z, final_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface pte_tan_if #(parameter int CW = 32);
    logic          valid;
    logic          ready;
    logic signed [CW-1:0] tangent_x;
    logic signed [CW-1:0] tangent_y;
    logic signed [CW-1:0] tangent_z;
    logic          run_end;

    modport source (output valid, tangent_x, tangent_y, tangent_z, run_end, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, run_end, output ready);
endinterface

/* sv/polyline_tangent_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_tangent_estimator
// One point per beat in, one tangent per point out, one point late.
// A segment normalizes one vector; a middle point normalizes two (its
// segment and the summed directions); a final point adds a second beat.
// All arithmetic runs on the single iterative unit (32-step multiply,
// 64-step divide, 32-step root); a new point is taken only in idle.
// Reset: synchronous, active low; clears the run state and output valid, restores the register defaults.
// ----------------------------------------------------------------------------
module polyline_tangent_estimator #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pte_pt_if.sink      i_pts,
    pte_tan_if.source   o_tan,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW   = COORD_WIDTH;
    localparam int MW   = (CW > 32) ? CW : 32;
    localparam int VW   = MW + 1;
    localparam int LW   = MW;
    localparam int DSTW = MW + 1;
    localparam int AW   = (LW + 31 > 64) ? LW + 31 : 64;
    localparam int PW   = AW - 30;
    localparam int TOL0 = FRAC_BITS;
    localparam int TOL1 = 60 - FRAC_BITS;

    localparam logic [MW-1:0] TWO31 = MW'(64'd2147483648);
    localparam logic [MW-1:0] TWO30 = MW'(64'd1073741824);
    localparam logic [MW-1:0] TWO29 = MW'(64'd536870912);
    localparam logic [AW-1:0] RND   = AW'(1) << 29;
    localparam logic [PW-1:0] MAXP  = (PW'(1) << (CW - 1)) - PW'(1);
    localparam logic [PW-1:0] MINP  = PW'(1) << (CW - 1);

    localparam logic [1:0] PS_EMPTY  = 2'd0;
    localparam logic [1:0] PS_FIRST  = 2'd1;
    localparam logic [1:0] PS_MIDDLE = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PREP  = 12'b0000_0000_0010,
        S_SQT   = 12'b0000_0000_0100,
        S_TOL   = 12'b0000_0000_1000,
        S_SCALE = 12'b0000_0001_0000,
        S_SQ    = 12'b0000_0010_0000,
        S_ROOT  = 12'b0000_0100_0000,
        S_DIST  = 12'b0000_1000_0000,
        S_DIV   = 12'b0001_0000_0000,
        S_NORM  = 12'b0010_0000_0000,
        S_EMIT  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state                r_state;
    logic [1:0]            r_ps;
    logic                  r_fin;
    logic                  r_endf;
    logic                  r_pass;
    logic [1:0]            r_idx;
    logic                  r_go;
    logic                  r_tiny;
    logic [5:0]            r_l;
    logic [5:0]            r_r;
    logic signed [CW-1:0]  r_p    [3];
    logic signed [CW-1:0]  r_held [3];
    logic signed [31:0]    r_inc  [3];
    logic signed [31:0]    r_o    [3];
    logic signed [31:0]    r_unit [3];
    logic signed [VW-1:0]  r_vec  [3];
    logic [MW-1:0]         r_m    [3];
    logic [MW-1:0]         r_mx;
    logic [AW-1:0]         r_sq;
    logic [31:0]           r_len;
    logic [DSTW-1:0]       r_dist;
    logic [LW-1:0]         r_tlen;
    logic [CW-1:0]         r_tan  [3];
    logic                  r_ov;
    logic [CW-1:0]         r_ox;
    logic [CW-1:0]         r_oy;
    logic [CW-1:0]         r_oz;
    logic                  r_oend;
    logic [30:0]           r_lastlen;
    logic [15:0]           r_ztol;

    pte_pkg::t_cmd  w_cmd;
    pte_pkg::t_stat w_stat;
    logic [AW-1:0]  w_opa;
    logic [AW-1:0]  w_opb;
    logic [AW-1:0]  w_res;
    logic [MW-1:0]  w_m [3];
    logic [MW-1:0]  w_mx;
    logic           w_tiny;
    logic [DSTW-1:0] w_dist;
    logic [31:0]    w_q;
    logic [31:0]    w_um;
    logic [PW-1:0]  w_p;
    logic [CW-1:0]  w_tan;
    logic           w_cfg_wr;

    pte_iter #(.W(AW)) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    always_comb begin
        logic [VW-1:0] neg;
        w_mx = '0;
        for (int i = 0; i < 3; i++) begin
            neg    = -r_vec[i];
            w_m[i] = r_vec[i][VW-1] ? neg[MW-1:0] : r_vec[i][MW-1:0];
            if (w_m[i] > w_mx) begin
                w_mx = w_m[i];
            end
        end
    end

    always_comb begin
        logic [AW-1:0]   sh;
        logic [DSTW-1:0] lenx;
        sh     = r_pass ? (r_sq >> TOL1) : (r_sq >> TOL0);
        w_tiny = (sh < AW'(r_ztol));
        lenx   = DSTW'(r_len);
        w_dist = (r_l != 6'd0) ? (lenx >> r_l) : (lenx << r_r);
    end

    always_comb begin
        logic [PW-1:0] pc;
        w_q  = w_res[31:0];
        w_um = r_unit[r_idx][31] ? (32'd0 - 32'(r_unit[r_idx])) : 32'(r_unit[r_idx]);
        w_p  = PW'((w_res + RND) >> 30);
        if (r_unit[r_idx][31]) begin
            pc    = (w_p > MINP) ? MINP : w_p;
            w_tan = CW'(~pc + PW'(1));
        end else begin
            pc    = (w_p > MAXP) ? MAXP : w_p;
            w_tan = pc[CW-1:0];
        end
    end

    always_comb begin
        w_cmd.op = pte_pkg::OP_MUL;
        w_opa    = AW'(r_m[r_idx]);
        w_opb    = AW'(r_m[r_idx]);
        case (r_state)
            S_ROOT: begin
                w_cmd.op = pte_pkg::OP_SQRT;
                w_opa    = r_sq;
            end
            S_DIV: begin
                w_cmd.op = pte_pkg::OP_DIV;
                w_opa    = (AW'(r_m[r_idx]) << pte_pkg::UNIT_SHIFT) + AW'(r_len >> 1);
                w_opb    = AW'(r_len);
            end
            S_EMIT: begin
                w_opa = AW'(w_um);
                w_opb = AW'(r_tlen);
            end
            default: begin
                w_cmd.op = pte_pkg::OP_MUL;
            end
        endcase
        w_cmd.start = !r_go && (r_state == S_SQT || r_state == S_SQ || r_state == S_ROOT ||
                                r_state == S_DIV || r_state == S_EMIT);
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == pte_pkg::REG_ZERO_TOL) ? 32'(r_ztol) : 32'(r_lastlen);

    assign i_pts.ready     = (r_state == S_IDLE);
    assign o_tan.valid     = r_ov;
    assign o_tan.tangent_x = r_ox;
    assign o_tan.tangent_y = r_oy;
    assign o_tan.tangent_z = r_oz;
    assign o_tan.run_end   = r_oend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ps      <= PS_EMPTY;
            r_ov      <= 1'b0;
            r_go      <= 1'b0;
            r_lastlen <= 31'd6553600;
            r_ztol    <= 16'd1;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[2])
                    pte_pkg::REG_LAST_LEN: r_lastlen <= pwdata[30:0];
                    pte_pkg::REG_ZERO_TOL: r_ztol    <= pwdata[15:0];
                    default: r_ztol <= r_ztol;
                endcase
            end
            if (o_tan.valid && o_tan.ready) begin
                r_ov <= 1'b0;
            end
            if (w_cmd.start) begin
                r_go <= 1'b1;
            end
            if (w_stat.done) begin
                r_go <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_pts.valid) begin
                        r_p[0] <= i_pts.point_x;
                        r_p[1] <= i_pts.point_y;
                        r_p[2] <= i_pts.point_z;
                        r_fin  <= i_pts.final_point;
                        r_endf <= 1'b0;
                        r_pass <= 1'b0;
                        if (r_ps == PS_EMPTY) begin
                            if (i_pts.final_point) begin
                                for (int i = 0; i < 3; i++) r_tan[i] <= '0;
                                r_endf  <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_held[0] <= i_pts.point_x;
                                r_held[1] <= i_pts.point_y;
                                r_held[2] <= i_pts.point_z;
                                r_ps      <= PS_FIRST;
                            end
                        end else begin
                            r_vec[0] <= VW'(i_pts.point_x) - VW'(r_held[0]);
                            r_vec[1] <= VW'(i_pts.point_y) - VW'(r_held[1]);
                            r_vec[2] <= VW'(i_pts.point_z) - VW'(r_held[2]);
                            r_state  <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_l    <= '0;
                    r_r    <= '0;
                    r_tiny <= 1'b0;
                    r_sq   <= '0;
                    r_idx  <= '0;
                    if (w_mx == '0) begin
                        for (int i = 0; i < 3; i++) r_unit[i] <= '0;
                        r_dist  <= '0;
                        r_state <= S_NORM;
                    end else begin
                        for (int i = 0; i < 3; i++) r_m[i] <= w_m[i];
                        r_mx    <= w_mx;
                        r_state <= (w_mx <= TWO31) ? S_SQT : S_SCALE;
                    end
                end
                S_SQT: begin
                    if (w_stat.done) begin
                        r_sq <= r_sq + w_res;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_state <= S_TOL;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                S_TOL: begin
                    r_tiny  <= w_tiny;
                    r_sq    <= '0;
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (r_mx >= TWO30) begin
                        r_mx <= r_mx >> 1;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                        r_r  <= r_r + 6'd1;
                    end else if (r_mx < TWO29) begin
                        r_mx <= r_mx << 1;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                        r_l  <= r_l + 6'd1;
                    end else begin
                        r_idx   <= '0;
                        r_sq    <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_stat.done) begin
                        r_sq <= r_sq + w_res;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_state <= S_ROOT;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                S_ROOT: begin
                    if (w_stat.done) begin
                        r_len   <= w_res[31:0];
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    r_dist <= w_dist;
                    r_idx  <= '0;
                    if (r_tiny) begin
                        for (int i = 0; i < 3; i++) r_unit[i] <= '0;
                        r_state <= S_NORM;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_stat.done) begin
                        r_unit[r_idx] <= r_vec[r_idx][VW-1] ? $signed(32'd0 - w_q) : $signed(w_q);
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_state <= S_NORM;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                S_NORM: begin
                    r_idx <= '0;
                    if (!r_pass) begin
                        for (int i = 0; i < 3; i++) r_o[i] <= r_unit[i];
                        r_tlen <= LW'(r_dist >> 1);
                        if (r_ps == PS_FIRST) begin
                            r_state <= S_EMIT;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_vec[i] <= VW'(r_inc[i]) + VW'(r_unit[i]);
                            end
                            r_pass  <= 1'b1;
                            r_state <= S_PREP;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_stat.done) begin
                        r_tan[r_idx] <= w_tan;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_tan.ready) begin
                        r_ov   <= 1'b1;
                        r_ox   <= r_tan[0];
                        r_oy   <= r_tan[1];
                        r_oz   <= r_tan[2];
                        r_oend <= r_endf;
                        if (r_endf) begin
                            r_ps    <= PS_EMPTY;
                            r_state <= S_IDLE;
                        end else if (r_fin) begin
                            for (int i = 0; i < 3; i++) r_unit[i] <= r_o[i];
                            r_tlen  <= LW'(r_lastlen);
                            r_endf  <= 1'b1;
                            r_idx   <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_inc[i]  <= r_o[i];
                                r_held[i] <= r_p[i];
                            end
                            r_ps    <= PS_MIDDLE;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/pte_iter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_iter
// Shared iterative unit: shift-add multiply, restoring divide, integer root.
// ----------------------------------------------------------------------------
module pte_iter #(
    parameter int W = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pte_pkg::t_cmd  i_cmd,
    input  logic [W-1:0]   i_opa,
    input  logic [W-1:0]   i_opb,
    output pte_pkg::t_stat o_stat,
    output logic [W-1:0]   o_res
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    r_acc;
    logic [W-1:0]    r_a;
    logic [W-1:0]    r_b;
    logic [CNTW-1:0] r_cnt;
    pte_pkg::t_op    r_op;
    logic            r_busy;
    logic            r_done;

    logic [W-1:0] w_t;
    logic         w_ge;
    logic [W-1:0] w_sum;
    logic         w_sge;

    assign w_t   = {r_acc[W-2:0], r_a[W-1]};
    assign w_ge  = (w_t >= r_b);
    assign w_sum = r_b + r_a;
    assign w_sge = (r_acc >= w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_op   <= i_cmd.op;
                r_busy <= 1'b1;
                case (i_cmd.op)
                    pte_pkg::OP_MUL: begin
                        r_acc <= '0;
                        r_a   <= i_opa;
                        r_b   <= i_opb;
                        r_cnt <= CNTW'(32);
                    end
                    pte_pkg::OP_DIV: begin
                        r_acc <= '0;
                        r_a   <= i_opa;
                        r_b   <= i_opb;
                        r_cnt <= CNTW'(W);
                    end
                    default: begin
                        r_acc <= i_opa;
                        r_a   <= W'(1) << 62;
                        r_b   <= '0;
                        r_cnt <= CNTW'(32);
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    pte_pkg::OP_MUL: begin
                        r_acc <= (r_acc << 1) + (r_a[31] ? r_b : '0);
                        r_a   <= r_a << 1;
                    end
                    pte_pkg::OP_DIV: begin
                        r_acc <= w_ge ? (w_t - r_b) : w_t;
                        r_a   <= {r_a[W-2:0], w_ge};
                    end
                    default: begin
                        if (w_sge) begin
                            r_acc <= r_acc - w_sum;
                            r_b   <= (r_b >> 1) + r_a;
                        end else begin
                            r_b   <= r_b >> 1;
                        end
                        r_a <= r_a >> 2;
                    end
                endcase
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (r_op)
            pte_pkg::OP_MUL: o_res = r_acc;
            pte_pkg::OP_DIV: o_res = r_a;
            default:         o_res = r_b;
        endcase
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* sv/pte_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_chk
// Port-level checks for the polyline tangent estimator.
// ----------------------------------------------------------------------------
module pte_chk #(
    parameter int CW = 32
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [CW-1:0] i_out_x,
    input logic [CW-1:0] i_out_y,
    input logic [CW-1:0] i_out_z,
    input logic          i_out_end
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output beat survives reset");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result loaded while input side was ready");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_x) && $stable(i_out_y) &&
                                        $stable(i_out_z) && $stable(i_out_end))
        else $error("output beat changed while stalled");

endmodule

bind polyline_tangent_estimator pte_chk #(.CW(COORD_WIDTH)) u_pte_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pts.ready),
    .i_out_valid (o_tan.valid),
    .i_out_ready (o_tan.ready),
    .i_out_x     (o_tan.tangent_x),
    .i_out_y     (o_tan.tangent_y),
    .i_out_z     (o_tan.tangent_z),
    .i_out_end   (o_tan.run_end)
);

/* tb/polyline_tangent_estimator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_tangent_estimator_tb
// Streams polylines of Q16.16 points into the tangent estimator and checks
// every tangent beat against a cycle-free fixed-point model of the block,
// over several register settings, with random gaps and a long output stall.
// ----------------------------------------------------------------------------
module polyline_tangent_estimator_tb;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int SETTLE_CYCLES  = 1500;
    localparam logic [63:0] UNIT_ONE = 64'd1 << 30;

    typedef logic signed [63:0] t_vec3 [3];

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               fin;
    } t_point;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               run_end;
    } t_tangent;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    pte_pt_if  #(.CW(32)) pts ();
    pte_tan_if #(.CW(32)) tan ();

    polyline_tangent_estimator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pts(pts), .o_tan(tan),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // model state
    logic [30:0] last_len;
    logic [15:0] zero_tol;
    logic signed [63:0] held [3];
    logic signed [63:0] in_dir [3];
    int unsigned seen;

    t_point   point_q [$];
    t_tangent tangent_q [$];
    t_point   cur_pt;
    int  fail_cnt, beats_in, beats_out, run_ends;
    bit  tx_valid, took_pt, took_tan, gap_free, hold_req, hold_done;
    int  tx_gap, rx_gap, hold_left, idle_cnt;
    t_point last_pt;

    function automatic logic [63:0] mag(logic signed [63:0] a);
        return a < 0 ? -a : a;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] unitise(input t_vec3 d, output t_vec3 u, input int sh);
        logic [63:0] m [3];
        logic [63:0] mx, sq, len, seg_len;
        int l, r;
        bit tiny;
        mx = 0;
        l = 0;
        r = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(d[i]);
            if (m[i] > mx) mx = m[i];
            u[i] = 0;
        end
        if (mx == 0) return 0;
        tiny = 0;
        if (mx <= (64'd1 << 31)) begin
            sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            tiny = (sq >> sh) < {48'd0, zero_tol};
        end
        while (mx >= UNIT_ONE) begin mx = mx >> 1; r++; end
        while (mx < (UNIT_ONE >> 1)) begin mx = mx << 1; l++; end
        for (int i = 0; i < 3; i++) m[i] = r != 0 ? (m[i] >> r) : (m[i] << l);
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = isqrt(sq);
        seg_len = l != 0 ? (len >> l) : (len << r);
        if (tiny) return seg_len;
        for (int i = 0; i < 3; i++) begin
            logic signed [63:0] q;
            q = ((m[i] << 30) + (len >> 1)) / len;
            u[i] = d[i] < 0 ? -q : q;
        end
        return seg_len;
    endfunction

    function automatic logic signed [31:0] scale(logic signed [63:0] u, logic [63:0] len);
        logic [63:0] um, p;
        um = mag(u);
        p = ((um * (len >> 32)) << 2) + ((um * {32'd0, len[31:0]} + (64'd1 << 29)) >> 30);
        if (u < 0) begin
            if (p > (64'd1 << 31)) p = 64'd1 << 31;
            p = -p;
            return p[31:0];
        end
        if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
        return p[31:0];
    endfunction

    function automatic t_tangent make_tan(t_vec3 dir, logic [63:0] len, logic e);
        t_tangent t;
        t.x = scale(dir[0], len);
        t.y = scale(dir[1], len);
        t.z = scale(dir[2], len);
        t.run_end = e;
        return t;
    endfunction

    task automatic predict_tangents(t_point pt);
        t_vec3 p, d, o, s, t, z;
        logic [63:0] seg_len, ign;
        p[0] = pt.x;
        p[1] = pt.y;
        p[2] = pt.z;
        for (int i = 0; i < 3; i++) z[i] = 0;
        if (seen == 0) begin
            if (pt.fin) begin
                tangent_q.push_back(make_tan(z, 0, 1'b1));
                return;
            end
        end else begin
            for (int i = 0; i < 3; i++) d[i] = p[i] - held[i];
            seg_len = unitise(d, o, 16);
            if (seen == 1) begin
                tangent_q.push_back(make_tan(o, seg_len >> 1, 1'b0));
            end else begin
                for (int i = 0; i < 3; i++) s[i] = in_dir[i] + o[i];
                ign = unitise(s, t, 44);
                tangent_q.push_back(make_tan(t, seg_len >> 1, 1'b0));
            end
            if (pt.fin) begin
                tangent_q.push_back(make_tan(o, {33'd0, last_len}, 1'b1));
                seen = 0;
                return;
            end
            for (int i = 0; i < 3; i++) in_dir[i] = o[i];
        end
        for (int i = 0; i < 3; i++) held[i] = p[i];
        seen = seen == 0 ? 1 : 2;
    endtask

    // input acceptance and output checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            bit moved;
            moved = 0;
            if (pts.valid && pts.ready) begin
                predict_tangents(cur_pt);
                took_pt = 1;
                beats_in++;
                moved = 1;
            end
            if (tan.valid && tan.ready) begin
                t_tangent e;
                took_tan = 1;
                beats_out++;
                moved = 1;
                if (tangent_q.size() == 0) begin
                    $error("unexpected tangent beat x=%0d", tan.tangent_x);
                    fail_cnt++;
                end else begin
                    e = tangent_q.pop_front();
                    if (tan.tangent_x !== e.x) begin
                        $error("tangent_x exp %0d got %0d", e.x, tan.tangent_x);
                        fail_cnt++;
                    end
                    if (tan.tangent_y !== e.y) begin
                        $error("tangent_y exp %0d got %0d", e.y, tan.tangent_y);
                        fail_cnt++;
                    end
                    if (tan.tangent_z !== e.z) begin
                        $error("tangent_z exp %0d got %0d", e.z, tan.tangent_z);
                        fail_cnt++;
                    end
                    if (tan.run_end !== e.run_end) begin
                        $error("run_end exp %0b got %0b", e.run_end, tan.run_end);
                        fail_cnt++;
                    end
                    if (e.run_end) run_ends++;
                end
            end
            idle_cnt <= moved ? 0 : idle_cnt + 1;
        end
    end

    // point driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pts.valid <= 1'b0;
            tx_valid = 0;
        end else if (!tx_valid || took_pt) begin
            took_pt = 0;
            if (tx_gap > 0) begin
                tx_gap--;
                pts.valid <= 1'b0;
                tx_valid = 0;
            end else if (point_q.size() != 0) begin
                cur_pt = point_q.pop_front();
                pts.point_x <= cur_pt.x;
                pts.point_y <= cur_pt.y;
                pts.point_z <= cur_pt.z;
                pts.final_point <= cur_pt.fin;
                pts.valid <= 1'b1;
                tx_valid = 1;
                tx_gap = gap_free ? 0 : $urandom_range(0, 7);
            end else begin
                pts.valid <= 1'b0;
                tx_valid = 0;
            end
        end
    end

    // tangent receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tan.ready <= 1'b0;
        end else begin
            if (took_tan) begin
                took_tan = 0;
                rx_gap = gap_free ? 0 : $urandom_range(0, 7);
            end
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = 4000;
            end
            if (hold_left > 0) begin
                hold_left--;
                tan.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                tan.ready <= 1'b0;
            end else begin
                tan.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == 3'(4 * pte_pkg::REG_LAST_LEN)) last_len = data[30:0];
        else if (addr == 3'(4 * pte_pkg::REG_ZERO_TOL)) zero_tol = data[15:0];
    endtask

    task automatic push_pt(logic signed [31:0] x, y, z, logic f);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.fin = f;
        point_q.push_back(p);
        last_pt = p;
    endtask

    function automatic logic signed [31:0] near_coord(logic signed [31:0] c);
        case ($urandom_range(0, 3))
            0: return c + $signed($urandom_range(0, 4)) - 2;
            1: return c + $signed($urandom_range(0, 512)) - 256;
            2: return c + $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_runs(int n);
        int cnt, len;
        cnt = 0;
        while (cnt < n) begin
            len = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 7);
            for (int k = 0; k < len; k++) begin
                logic f;
                f = (k == len - 1);
                if ($urandom_range(0, 19) == 0) f = ~f;
                if (k == 0 || $urandom_range(0, 4) == 0)
                    push_pt($urandom, $urandom, $urandom, f);
                else if ($urandom_range(0, 14) == 0)
                    push_pt(last_pt.x, last_pt.y, last_pt.z, f);
                else
                    push_pt(near_coord(last_pt.x), near_coord(last_pt.y),
                            near_coord(last_pt.z), f);
                cnt++;
            end
        end
    endtask

    task automatic drain;
        while (point_q.size() != 0 || tx_valid || tangent_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pts.valid = 1'b0;
        pts.point_x = '0;
        pts.point_y = '0;
        pts.point_z = '0;
        pts.final_point = 1'b0;
        tan.ready = 1'b0;
        last_len = 31'd6553600;
        zero_tol = 16'd1;
        seen = 0;
        for (int i = 0; i < 3; i++) begin
            held[i] = 0;
            in_dir[i] = 0;
        end
        fail_cnt = 0;
        idle_cnt = 0;
        tx_gap = 0;
        rx_gap = 0;
        hold_left = 0;
        gap_free = 0;
        hold_req = 0;
        hold_done = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: lone point, extremes, repeated point, unit step, reversal
        push_pt(32'sd5, -32'sd7, 32'sd9, 1'b1);
        push_pt(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        push_pt(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        push_pt(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 1'b1);
        push_pt(32'sd0, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sd0, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sd1, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sd1, 32'sd1, 32'sd0, 1'b1);
        push_pt(32'sd0, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sd65536, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sd0, 32'sd0, 32'sd0, 1'b0);
        push_pt(-32'sd65536, 32'sd131072, 32'sd196608, 1'b1);
        push_pt(32'sd100, -32'sd100, 32'sd0, 1'b1);
        fill_runs(100);
        drain();

        reg_write(3'(4 * pte_pkg::REG_LAST_LEN), 32'd0);
        reg_write(3'(4 * pte_pkg::REG_ZERO_TOL), 32'd0);
        push_pt(32'sd0, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sd1, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sd0, 32'sd0, 32'sd0, 1'b1);
        hold_req = 1;
        gap_free = 1;
        fill_runs(120);
        drain();
        gap_free = 0;

        reg_write(3'(4 * pte_pkg::REG_LAST_LEN), 32'h7FFF_FFFF);
        reg_write(3'(4 * pte_pkg::REG_ZERO_TOL), 32'd65535);
        push_pt(32'sd0, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sd255, 32'sd0, 32'sd0, 1'b0);
        push_pt(32'sh0100_0000, -32'sh0100_0000, 32'sd0, 1'b1);
        fill_runs(120);
        drain();

        reg_write(3'(4 * pte_pkg::REG_LAST_LEN), $urandom);
        reg_write(3'(4 * pte_pkg::REG_ZERO_TOL), $urandom_range(0, 300));
        fill_runs(120);
        drain();

        reg_write(3'(4 * pte_pkg::REG_LAST_LEN), 32'd6553600);
        reg_write(3'(4 * pte_pkg::REG_ZERO_TOL), 32'd1);
        fill_runs(120);
        drain();

        $display("Run covered %0d point beats and %0d tangent beats (%0d polyline ends)",
                 beats_in, beats_out, run_ends);
        $display("over five register settings, random gaps and one long output stall.");
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
